/* hdl/spmq_pkg.sv */
// types and codes shared by the shared-pool multi-queue block
// no dependencies; compiled before every other file of the block
package spmq_pkg;

    localparam int DATA_W = 32;

    // operation codes, the unused code acts as a query
    localparam logic [1:0] KIND_STORE = 2'd0;
    localparam logic [1:0] KIND_FETCH = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_POOL_FULL = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [2:0]        queue_id;
        logic [DATA_W-1:0] element_in;
    } spmq_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] element_out;
        logic [4:0]        queue_count;
        logic              queue_empty;
    } spmq_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EXEC
    } spmq_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic lookup;
        logic commit;
    } spmq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic acc_fetch;
        logic out_free;
    } spmq_stat_t;

endpackage

/* hdl/shared_pool_multi_queue_unit.sv */
// Shared-pool multi-queue unit: several FIFO queues linked through one entry pool.
// Input channel s_valid/s_ready/s_payload carries one operation per transaction:
// store an element at a queue's tail, fetch the head element, or query the count.
// Result channel m_valid/m_ready/m_payload returns one transaction per operation
// with status, fetched element, the queue's count and its empty flag.
// For a store or query, the queue record and the link of the free-list head are
// read from their memories when the operation is accepted, then committed in the
// EXEC state, which also registers the result. A fetch goes through LOOKUP first:
// the head entry's link and element can only be read once the queue record has
// been read, so they are fetched in LOOKUP before the commit in EXEC.
// One operation is in flight at a time; s_ready is high again in the
// cycle after the result is registered, even while that result is still waiting.
// A stalled receiver holds the operation in its final cycle until the output
// register frees up. Reset empties all queues and rebuilds the free list at once
// (per-queue valid bits and an allocation count), with no clearing pass.
// depends on spmq_pkg, spmq_ctrl and spmq_datapath
module shared_pool_multi_queue_unit #(
    parameter int POOL_SIZE     = 16,
    parameter int NUM_QUEUES    = 8,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  spmq_pkg::spmq_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output spmq_pkg::spmq_out_t m_payload
);
    import spmq_pkg::*;

    spmq_cmd_t  cmd;
    spmq_stat_t stat;

    spmq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    spmq_datapath #(
        .POOL_SIZE     (POOL_SIZE),
        .NUM_QUEUES    (NUM_QUEUES),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

/* hdl/spmq_ctrl.sv */
// sequencing state machine of the shared-pool multi-queue block
// depends on spmq_pkg
module spmq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  spmq_pkg::spmq_stat_t stat,
    output spmq_pkg::spmq_cmd_t  cmd
);
    import spmq_pkg::*;

    spmq_state_t state_reg;
    spmq_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                // a fetch needs the head entry read before it can commit
                if (s_valid) begin
                    state_next = stat.acc_fetch ? ST_LOOKUP : ST_EXEC;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.accept = 1'b0;
        cmd.lookup = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
            end
            ST_EXEC: begin
                // hold while the output register is still occupied
                cmd.commit = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/spmq_datapath.sv */
// pointer and element memories, free list and result register
// depends on spmq_pkg; driven by spmq_ctrl commands
module spmq_datapath #(
    parameter int POOL_SIZE     = 16,
    parameter int NUM_QUEUES    = 8,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  spmq_pkg::spmq_cmd_t  cmd,
    output spmq_pkg::spmq_stat_t stat,
    input  spmq_pkg::spmq_in_t   s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output spmq_pkg::spmq_out_t  m_payload
);
    import spmq_pkg::*;

    localparam int PW = $clog2(POOL_SIZE + 1);
    localparam int AW = $clog2(POOL_SIZE);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CW = PW;
    localparam int DW = (ELEMENT_WIDTH < DATA_W) ? ELEMENT_WIDTH : DATA_W;
    localparam logic [PW-1:0] PTR_NULL = PW'(POOL_SIZE);
    localparam logic [8:0]    NQ       = 9'(NUM_QUEUES);

    typedef struct packed {
        logic [PW-1:0] head;
        logic [PW-1:0] tail;
        logic [CW-1:0] count;
    } qrec_t;

    logic [DW-1:0] data_mem [POOL_SIZE];
    logic [PW-1:0] next_mem [POOL_SIZE];
    qrec_t         q_mem    [NUM_QUEUES];

    logic [NUM_QUEUES-1:0] qvalid_reg;
    logic [PW-1:0]         free_head_reg, free_head_next;
    // entries at and above fill_reg were never allocated and chain i to i+1
    logic [PW-1:0]         fill_reg, fill_next;

    spmq_in_t  item_reg;
    qrec_t     q_rd_reg;
    logic      qv_rd_reg;
    logic [PW-1:0] next_rd_reg;
    logic [DW-1:0] data_rd_reg;

    spmq_out_t out_reg, out_next;
    logic      out_valid_reg;

    logic [QW-1:0] acc_qidx, qidx;
    logic [AW-1:0] fh_addr, head_addr, tail_addr;
    logic          q_ok, is_store, is_fetch, fh_null, fh_fresh;
    logic [PW-1:0] cur_head, cur_tail;
    logic [CW-1:0] cur_cnt;
    qrec_t         q_new;
    logic          data_we, next_we;
    logic [AW-1:0] next_waddr;
    logic [PW-1:0] next_wdata;
    logic [1:0]    res_status;
    logic [DW-1:0] res_elem;

    assign acc_qidx  = QW'(s_payload.queue_id);
    assign qidx      = QW'(item_reg.queue_id);
    assign fh_null   = (free_head_reg == PTR_NULL);
    assign fh_fresh  = (free_head_reg >= fill_reg);
    assign fh_addr   = fh_null ? '0 : free_head_reg[AW-1:0];

    assign q_ok      = ({6'd0, item_reg.queue_id} < NQ);
    assign is_store  = (item_reg.kind == KIND_STORE);
    assign is_fetch  = (item_reg.kind == KIND_FETCH);
    assign cur_cnt   = qv_rd_reg ? q_rd_reg.count : '0;
    assign cur_head  = qv_rd_reg ? q_rd_reg.head  : PTR_NULL;
    assign cur_tail  = qv_rd_reg ? q_rd_reg.tail  : PTR_NULL;
    assign head_addr = (cur_head == PTR_NULL) ? '0 : cur_head[AW-1:0];
    assign tail_addr = (cur_tail == PTR_NULL) ? '0 : cur_tail[AW-1:0];

    assign stat.acc_fetch = (s_payload.kind == KIND_FETCH);
    assign stat.out_free  = !out_valid_reg || m_ready;

    always_comb begin
        q_new.head     = cur_head;
        q_new.tail     = cur_tail;
        q_new.count    = cur_cnt;
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        data_we        = 1'b0;
        next_we        = 1'b0;
        next_waddr     = tail_addr;
        next_wdata     = free_head_reg;
        res_status     = STATUS_OK;
        res_elem       = '0;
        if (q_ok && is_store) begin
            if (fh_null) begin
                res_status = STATUS_POOL_FULL;
            end else begin
                data_we     = 1'b1;
                q_new.head  = (cur_cnt == '0) ? free_head_reg : cur_head;
                q_new.tail  = free_head_reg;
                q_new.count = cur_cnt + CW'(1);
                // link the old tail; the new tail's own link is never followed
                next_we     = (cur_cnt != '0);
                next_waddr  = tail_addr;
                next_wdata  = free_head_reg;
                if (fh_fresh) begin
                    free_head_next = free_head_reg + PW'(1);
                    fill_next      = fill_reg + PW'(1);
                end else begin
                    free_head_next = next_rd_reg;
                end
            end
        end else if (q_ok && is_fetch) begin
            if (cur_cnt == '0) begin
                res_status = STATUS_EMPTY;
            end else begin
                res_elem       = data_rd_reg;
                q_new.head     = (cur_cnt == CW'(1)) ? PTR_NULL : next_rd_reg;
                q_new.tail     = (cur_cnt == CW'(1)) ? PTR_NULL : cur_tail;
                q_new.count    = cur_cnt - CW'(1);
                // freed entry goes on top of the free list
                next_we        = 1'b1;
                next_waddr     = head_addr;
                next_wdata     = free_head_reg;
                free_head_next = cur_head;
            end
        end
    end

    always_comb begin
        if (q_ok) begin
            out_next.status      = res_status;
            out_next.element_out = DATA_W'(res_elem);
            out_next.queue_count = 5'(q_new.count);
            out_next.queue_empty = (q_new.count == '0);
        end else begin
            out_next.status      = STATUS_OK;
            out_next.element_out = '0;
            out_next.queue_count = '0;
            out_next.queue_empty = 1'b1;
        end
    end

    // memories and their registered reads
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg    <= s_payload;
            q_rd_reg    <= q_mem[acc_qidx];
            qv_rd_reg   <= qvalid_reg[acc_qidx];
            next_rd_reg <= next_mem[fh_addr];
        end
        if (cmd.lookup) begin
            next_rd_reg <= next_mem[head_addr];
            data_rd_reg <= data_mem[head_addr];
        end
        if (cmd.commit && data_we) begin
            data_mem[fh_addr] <= item_reg.element_in[DW-1:0];
        end
        if (cmd.commit && next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (cmd.commit && q_ok) begin
            q_mem[qidx] <= q_new;
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qvalid_reg    <= '0;
            free_head_reg <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit && q_ok) begin
                qvalid_reg[qidx] <= 1'b1;
            end
            if (cmd.commit) begin
                free_head_reg <= free_head_next;
                fill_reg      <= fill_next;
            end
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

endmodule

/* hdl/spmq_checker.sv */
// port-level checks for shared_pool_multi_queue_unit, bound to the top level
// depends on spmq_pkg
module spmq_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input spmq_pkg::spmq_in_t  s_payload,
    input logic                m_valid,
    input logic                m_ready,
    input spmq_pkg::spmq_out_t m_payload
);
    import spmq_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // one operation at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second operation taken while one is in flight");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.queue_empty |-> m_payload.queue_count == 5'd0)
        else $error("empty flag with non-zero count");

    a_fail_no_elem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status != STATUS_OK |-> m_payload.element_out == '0)
        else $error("element returned on a failed operation");

    a_fetch_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status == STATUS_EMPTY |-> m_payload.queue_empty)
        else $error("empty status on a non-empty queue");

endmodule

bind shared_pool_multi_queue_unit spmq_checker u_spmq_checker (.*);

/* verif/testbench.sv */
// testbench for shared_pool_multi_queue_unit: random and directed store/fetch/query traffic
// checked against a linked-pool predictor held in a small scoreboard class
// depends on spmq_pkg and the block's rtl
`timescale 1ns / 100ps

module testbench;
    import spmq_pkg::*;

    localparam int POOL       = 16;
    localparam int QUEUES     = 8;
    localparam logic [4:0] NO_ENTRY = 5'(POOL);
    // the fourth kind code, handled as a query
    localparam logic [1:0] KIND_SPARE = 2'd3;

    class pool_scoreboard;
        logic [DATA_W-1:0] word_of[POOL];
        logic [4:0]        link_of[POOL];
        logic [4:0]        free_top;
        logic [4:0]        first_of[QUEUES];
        logic [4:0]        last_of[QUEUES];
        int                depth_of[QUEUES];
        spmq_out_t         awaited[$];
        int                errors;

        function new();
            for (int i = 0; i < POOL; i++) begin
                word_of[i] = '0;
                link_of[i] = (i + 1 < POOL) ? 5'(i + 1) : NO_ENTRY;
            end
            free_top = 5'd0;
            for (int q = 0; q < QUEUES; q++) begin
                first_of[q] = NO_ENTRY;
                last_of[q]  = NO_ENTRY;
                depth_of[q] = 0;
            end
            errors = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // apply one accepted operation to the pool picture and queue its result
        function void note_op(spmq_in_t op);
            spmq_out_t  res;
            logic [2:0] q;
            logic [4:0] e;
            res = '0;
            q   = op.queue_id;
            case (op.kind)
                KIND_STORE: begin
                    e = free_top;
                    if (e == NO_ENTRY) begin
                        res.status = STATUS_POOL_FULL;
                    end else begin
                        free_top        = link_of[e[3:0]];
                        word_of[e[3:0]] = op.element_in;
                        link_of[e[3:0]] = NO_ENTRY;
                        if (last_of[q] != NO_ENTRY) link_of[last_of[q][3:0]] = e;
                        else first_of[q] = e;
                        last_of[q]  = e;
                        depth_of[q] = depth_of[q] + 1;
                    end
                end
                KIND_FETCH: begin
                    e = first_of[q];
                    if (e == NO_ENTRY) begin
                        res.status = STATUS_EMPTY;
                    end else begin
                        res.element_out = word_of[e[3:0]];
                        first_of[q]     = link_of[e[3:0]];
                        if (first_of[q] == NO_ENTRY) last_of[q] = NO_ENTRY;
                        if (depth_of[q] > 0) depth_of[q] = depth_of[q] - 1;
                        link_of[e[3:0]] = free_top;
                        free_top        = e;
                    end
                end
                default: ;
            endcase
            res.queue_count = 5'(depth_of[q]);
            res.queue_empty = (depth_of[q] == 0);
            awaited.push_back(res);
        endfunction

        function void field_check(string name, logic [DATA_W-1:0] want,
                                  logic [DATA_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_result(spmq_out_t got);
            spmq_out_t want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction, expected none, got %p",
                         $time, got);
                return;
            end
            want = awaited.pop_front();
            field_check("status", DATA_W'(want.status), DATA_W'(got.status));
            field_check("element_out", want.element_out, got.element_out);
            field_check("queue_count", DATA_W'(want.queue_count), DATA_W'(got.queue_count));
            field_check("queue_empty", DATA_W'(want.queue_empty), DATA_W'(got.queue_empty));
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    spmq_in_t  s_payload;
    logic      m_valid;
    logic      m_ready;
    spmq_out_t m_payload;

    pool_scoreboard sb;
    bit             quiet_phase;

    shared_pool_multi_queue_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin : watchdog
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic spmq_in_t make_op(logic [1:0] kind, logic [2:0] q,
                                         logic [DATA_W-1:0] word);
        spmq_in_t op;
        op.kind       = kind;
        op.queue_id   = q;
        op.element_in = word;
        return op;
    endfunction

    // mode 0 balanced, 1 store heavy, 2 fetch heavy, 3 balanced on a focus queue
    function automatic spmq_in_t random_op(int mode, logic [2:0] focus);
        int                r;
        int                store_lim;
        int                fetch_lim;
        logic [1:0]        kind;
        logic [2:0]        q;
        logic [DATA_W-1:0] word;
        store_lim = (mode == 1) ? 75 : (mode == 2) ? 15 : 45;
        fetch_lim = store_lim + ((mode == 1) ? 15 : (mode == 2) ? 75 : 45);
        r = $urandom_range(0, 99);
        if (r < store_lim) kind = KIND_STORE;
        else if (r < fetch_lim) kind = KIND_FETCH;
        else kind = $urandom_range(0, 1) ? KIND_QUERY : KIND_SPARE;
        if (mode == 3 && $urandom_range(0, 9) < 8) q = focus;
        else q = 3'($urandom_range(0, QUEUES - 1));
        r = $urandom_range(0, 9);
        if (r == 0) word = '0;
        else if (r == 1) word = '1;
        else word = $urandom;
        return make_op(kind, q, word);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic drive_op(spmq_in_t op);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= op;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_op(s_payload);
            if (m_valid && m_ready) sb.check_result(m_payload);
        end
    end

    initial begin : result_sink
        int len;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            len = idle_len();
            if (len > 0) begin
                m_ready <= 1'b0;
                repeat (len) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    end

    initial begin : stimulus
        int         mode;
        logic [2:0] focus;
        sb          = new();
        quiet_phase = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_payload   = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty queues, the spare kind code and the element extremes
        drive_op(make_op(KIND_QUERY, 3'd0, '0));
        drive_op(make_op(KIND_FETCH, 3'd0, '1));
        drive_op(make_op(KIND_SPARE, 3'd7, '1));
        drive_op(make_op(KIND_STORE, 3'd0, '0));
        drive_op(make_op(KIND_STORE, 3'd7, '1));
        drive_op(make_op(KIND_FETCH, 3'd7, '0));
        drive_op(make_op(KIND_FETCH, 3'd0, '0));
        // whole pool in one queue, count reaches its maximum, then exhaustion
        for (int i = 0; i < POOL; i++)
            drive_op(make_op(KIND_STORE, 3'd3, $urandom));
        drive_op(make_op(KIND_STORE, 3'd5, 32'h5a5a_a5a5));
        drive_op(make_op(KIND_FETCH, 3'd3, '0));
        drive_op(make_op(KIND_FETCH, 3'd5, '0));
        drive_op(make_op(KIND_QUERY, 3'd3, '0));
        s_valid <= 1'b0;
        wait_drained();
        @(negedge aclk);

        for (int blk = 0; blk < 9; blk++) begin
            mode        = $urandom_range(0, 3);
            focus       = 3'($urandom_range(0, QUEUES - 1));
            quiet_phase = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 100; n++) begin
                drive_op(random_op(mode, focus));
                // sender holds off until the block has answered everything
                if ((blk == 4 && n == 50) || (n == 99 && $urandom_range(0, 1))) begin
                    s_valid <= 1'b0;
                    wait_drained();
                    @(negedge aclk);
                end
            end
        end
        quiet_phase = 1'b0;
        s_valid <= 1'b0;

        wait_drained();
        repeat (8) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
